[rtl/core/lrf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lrf_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 128;
	localparam int STORE_DEPTH       = 2048;
	localparam int ADDR_W            = 11;
	localparam int COORD_W           = 16;
	localparam int CNT_W             = 17;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
	} pix_t;

	typedef struct packed {
		addr_t      rd_addr;
		logic       we;
		addr_t      wr_addr;
		logic [7:0] wr_data;
	} ram_req_t;

endpackage

`default_nettype wire

[rtl/core/lrf_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lrf_cmd_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            op;
	logic signed [15:0]    x_start;
	logic signed [15:0]    y_start;
	logic signed [15:0]    x_end;
	logic signed [15:0]    y_end;
	logic [10:0]           read_address;

	modport source (output valid, op, x_start, y_start, x_end, y_end, read_address,
		input ready);
	modport sink (input valid, op, x_start, y_start, x_end, y_end, read_address,
		output ready);
endinterface

interface lrf_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_byte;
	logic [16:0] pixels_written;

	modport source (output valid, read_byte, pixels_written, input ready);
	modport sink (input valid, read_byte, pixels_written, output ready);
endinterface

`default_nettype wire

[rtl/core/lrf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

[rtl/core/lrf_bres.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrf_bres (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire lrf_pkg::coord_t x0,
	input  wire lrf_pkg::coord_t y0,
	input  wire lrf_pkg::coord_t x1,
	input  wire lrf_pkg::coord_t y1,
	output lrf_pkg::pix_t       pix,
	output logic                busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STEEP = 3'd1;
	localparam logic [2:0] S_SWAP  = 3'd2;
	localparam logic [2:0] S_DELTA = 3'd3;
	localparam logic [2:0] S_PREP  = 3'd4;
	localparam logic [2:0] S_RUN   = 3'd5;

	logic [2:0] state_q;
	lrf_pkg::coord_t ax_q, ay_q, bx_q, by_q;
	lrf_pkg::coord_t maj_q, mnr_q, end_maj_q, end_mnr_q;
	logic steep_q, step_neg_q;
	logic [15:0] dx_q, dy_q, dxmdy_q, cnt_q;
	logic signed [17:0] err_q;

	logic signed [16:0] ddx, ddy, dmaj, dmnr;
	logic [16:0] adx, ady;
	logic [15:0] dx_w, dy_w;
	lrf_pkg::coord_t ma, mi, mb, nb;
	logic signed [17:0] e1, e2;

	always_comb begin
		ddx  = $signed({bx_q[15], bx_q}) - $signed({ax_q[15], ax_q});
		ddy  = $signed({by_q[15], by_q}) - $signed({ay_q[15], ay_q});
		adx  = ddx[16] ? 17'(-ddx) : 17'(ddx);
		ady  = ddy[16] ? 17'(-ddy) : 17'(ddy);
		ma   = steep_q ? ay_q : ax_q;
		mi   = steep_q ? ax_q : ay_q;
		mb   = steep_q ? by_q : bx_q;
		nb   = steep_q ? bx_q : by_q;
		dmaj = $signed({end_maj_q[15], end_maj_q}) - $signed({maj_q[15], maj_q});
		dmnr = $signed({end_mnr_q[15], end_mnr_q}) - $signed({mnr_q[15], mnr_q});
		dx_w = dmaj[15:0];
		dy_w = dmnr[16] ? 16'(-dmnr) : dmnr[15:0];
		e1   = err_q - $signed({2'b00, dy_q});
		e2   = err_q + $signed({2'b00, dxmdy_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (start) state_q <= S_STEEP;
				S_STEEP: state_q <= S_SWAP;
				S_SWAP:  state_q <= S_DELTA;
				S_DELTA: state_q <= S_PREP;
				S_PREP:  state_q <= S_RUN;
				S_RUN:   if (cnt_q == '0) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ax_q <= x0;
				ay_q <= y0;
				bx_q <= x1;
				by_q <= y1;
			end
			S_STEEP: steep_q <= ady > adx;
			S_SWAP: begin
				if (ma > mb) begin
					maj_q     <= mb;
					mnr_q     <= nb;
					end_maj_q <= ma;
					end_mnr_q <= mi;
				end else begin
					maj_q     <= ma;
					mnr_q     <= mi;
					end_maj_q <= mb;
					end_mnr_q <= nb;
				end
			end
			S_DELTA: begin
				dx_q       <= dx_w;
				dy_q       <= dy_w;
				cnt_q      <= dx_w;
				err_q      <= $signed({3'b000, dx_w[15:1]});
				step_neg_q <= !(mnr_q < end_mnr_q);
			end
			S_PREP: dxmdy_q <= dx_q - dy_q;
			S_RUN: begin
				maj_q <= maj_q + 16'sd1;
				cnt_q <= cnt_q - 16'd1;
				if (e1[17]) begin
					err_q <= e2;
					mnr_q <= step_neg_q ? mnr_q - 16'sd1 : mnr_q + 16'sd1;
				end else begin
					err_q <= e1;
				end
			end
			default: ;
		endcase
	end

	assign pix.valid = state_q == S_RUN;
	assign pix.x     = steep_q ? mnr_q : maj_q;
	assign pix.y     = steep_q ? maj_q : mnr_q;
	assign busy      = state_q != S_IDLE;

endmodule

`default_nettype wire

[rtl/core/lrf_plot.sv]
`timescale 1ns / 1ps
`default_nettype none

module lrf_plot #(
	parameter int SCREEN_WIDTH  = lrf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = lrf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire lrf_pkg::pix_t               pix,
	input  wire logic [7:0]                  rd_data,
	output lrf_pkg::ram_req_t                req,
	output logic [lrf_pkg::CNT_W-1:0]        count,
	output logic                             busy
);

	localparam int XW  = $clog2(SCREEN_WIDTH);
	localparam int YW  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int LW  = XW + YW;
	localparam int LIM = lrf_pkg::STORE_DEPTH * 8;

	typedef logic [LW-1:0] lin_t;

	logic            in_view;
	logic            v_s1, v_s2;
	logic [XW-1:0]   x_s1;
	lin_t            prod_s1;
	lin_t            lin;
	logic            idx_ok, hit;
	lrf_pkg::addr_t  addr_s2;
	logic [7:0]      mask_s2;
	logic            fwd_v_q;
	lrf_pkg::addr_t  fwd_addr_q;
	logic [7:0]      fwd_data_q;
	logic [7:0]      base;
	logic [lrf_pkg::CNT_W-1:0] count_q;

	assign in_view = !pix.x[15] && !pix.y[15]
		&& ({1'b0, pix.x[14:0]} < 16'(SCREEN_WIDTH))
		&& ({1'b0, pix.y[14:0]} < 16'(SCREEN_HEIGHT));

	assign lin    = prod_s1 + lin_t'(x_s1);
	assign idx_ok = 32'(lin) < LIM;
	assign hit    = v_s1 && idx_ok;
	assign base   = (fwd_v_q && fwd_addr_q == addr_s2) ? fwd_data_q : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			fwd_v_q <= 1'b0;
			count_q <= '0;
		end else begin
			v_s1 <= pix.valid && in_view;
			v_s2 <= hit;
			if (start) begin
				fwd_v_q <= 1'b0;
				count_q <= '0;
			end else begin
				if (v_s2) fwd_v_q <= 1'b1;
				if (hit) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= pix.x[XW-1:0];
		prod_s1 <= lin_t'(pix.y[YW-1:0] * SCREEN_WIDTH);
		addr_s2 <= lrf_pkg::addr_t'(lin >> 3);
		mask_s2 <= 8'd1 << x_s1[2:0];
		if (v_s2) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= base | mask_s2;
		end
	end

	assign req.rd_addr = lrf_pkg::addr_t'(lin >> 3);
	assign req.we      = v_s2;
	assign req.wr_addr = addr_s2;
	assign req.wr_data = base | mask_s2;
	assign count       = count_q;
	assign busy        = v_s1 || v_s2;

endmodule

`default_nettype wire

[rtl/core/line_rasterizer_framebuffer.sv]
`timescale 1ns / 1ps
`default_nettype none

// One-bit-per-pixel frame store (2048 bytes, eight pixels per byte, lowest bit
// leftmost) with a Bresenham line drawer. Each command word returns exactly one
// result word. A draw runs from accept through setup states that test the slope,
// order the endpoints, take the deltas and prepare the error step, then one pixel
// per cycle from the Bresenham stepper, then a drain through the
// read-modify-write stage of the single-port-write store, a finish state and
// the idle state. A read fetches one byte, a clear zeroes the store one byte
// per cycle, and after reset the store is swept to zero before the first command
// word is taken. One command is in flight at a time; a result word left waiting
// holds the next command in its finish state.
module line_rasterizer_framebuffer #(
	parameter int SCREEN_WIDTH  = lrf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = lrf_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lrf_cmd_if.sink   cmd,
	lrf_res_if.source res
);

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DRAW   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_READ_W = 3'd4;
	localparam logic [2:0] ST_FIN    = 3'd5;

	logic [2:0]          state_q;
	lrf_pkg::addr_t      clr_q;
	lrf_pkg::addr_t      raddr_q;
	logic [7:0]          byte_q;
	logic                is_draw_q;
	logic                out_v_q;
	logic [7:0]          out_byte_q;
	logic [lrf_pkg::CNT_W-1:0] out_cnt_q;
	logic                boot_q;

	logic                accept;
	logic                start;
	logic                bres_busy, plot_busy;
	lrf_pkg::pix_t       pix;
	lrf_pkg::ram_req_t   preq;
	logic [lrf_pkg::CNT_W-1:0] count;
	logic                ram_we;
	lrf_pkg::addr_t      ram_wr_addr, ram_rd_addr;
	logic [7:0]          ram_wr_data, ram_rd_data;

	assign cmd.ready = state_q == ST_IDLE;
	assign accept    = cmd.valid && cmd.ready;
	assign start     = accept && cmd.op == lrf_pkg::OP_DRAW;

	lrf_bres u_bres (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.x0     (cmd.x_start),
		.y0     (cmd.y_start),
		.x1     (cmd.x_end),
		.y1     (cmd.y_end),
		.pix    (pix),
		.busy   (bres_busy)
	);

	lrf_plot #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_plot (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.pix     (pix),
		.rd_data (ram_rd_data),
		.req     (preq),
		.count   (count),
		.busy    (plot_busy)
	);

	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we      = 1'b1;
			ram_wr_addr = clr_q;
			ram_wr_data = 8'd0;
		end else begin
			ram_we      = preq.we && state_q == ST_DRAW;
			ram_wr_addr = preq.wr_addr;
			ram_wr_data = preq.wr_data;
		end
		ram_rd_addr = (state_q == ST_READ) ? raddr_q : preq.rd_addr;
	end

	lrf_ram #(
		.WIDTH (8),
		.DEPTH (lrf_pkg::STORE_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && res.ready && state_q != ST_FIN) out_v_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= boot_q ? ST_IDLE : ST_FIN;
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd.op)
							lrf_pkg::OP_DRAW:  state_q <= ST_DRAW;
							lrf_pkg::OP_READ:  state_q <= ST_READ;
							lrf_pkg::OP_CLEAR: state_q <= ST_CLR;
							default:           state_q <= ST_FIN;
						endcase
					end
				end
				ST_DRAW:   if (!bres_busy && !plot_busy) state_q <= ST_FIN;
				ST_READ:   state_q <= ST_READ_W;
				ST_READ_W: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_v_q || res.ready) begin
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// set until the sweep after reset is done; that sweep returns no word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= 1'b1;
		end else if (state_q == ST_IDLE) begin
			boot_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raddr_q   <= cmd.read_address;
			is_draw_q <= cmd.op == lrf_pkg::OP_DRAW;
			byte_q    <= 8'd0;
		end
		if (state_q == ST_READ_W) byte_q <= ram_rd_data;
		if (state_q == ST_FIN && (!out_v_q || res.ready)) begin
			out_byte_q <= byte_q;
			out_cnt_q  <= is_draw_q ? count : '0;
		end
	end

	assign res.valid          = out_v_q;
	assign res.read_byte      = out_byte_q;
	assign res.pixels_written = out_cnt_q;

	ap_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLR || state_q == ST_DRAW))
		else $error("store written outside clear or draw");

	ap_step_draw: assert property (@(posedge clk) disable iff (!arst_n)
		bres_busy |-> state_q == ST_DRAW)
		else $error("stepper running outside draw");

	ap_out_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q) == ST_FIN)
		else $error("result word raised outside finish");

endmodule

`default_nettype wire
